>>> rtl/gafrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gafrs_pkg - shared types and constants for the fitness roulette selector
// Operation codes, sequencer states, field widths and the gene score function.
// ----------------------------------------------------------------------------
package gafrs_pkg;

  localparam int POP_SIZE     = 64;
  localparam int GENE_BITS    = 16;
  localparam int RAND_BITS    = 16;
  localparam int SCORE_W      = 5;
  localparam int SLOT_W       = 6;
  localparam int SUM_W        = 11;
  localparam int TARGET_RESET = 16;
  localparam int NIBBLES      = GENE_BITS / 4;

  typedef enum logic [1:0] {
    OP_EVAL   = 2'd0,
    OP_RECORD = 2'd1,
    OP_SELECT = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MOD,
    ST_PRIME,
    ST_WALK,
    ST_FINISH
  } state_t;

  // Score of a gene is its count of one bits, summed a nibble at a time.
  function automatic logic [SCORE_W-1:0] gene_score(input logic [GENE_BITS-1:0] g);
    logic [SCORE_W-1:0] total;
    logic [2:0]         nib_cnt;
    total = '0;
    for (int n = 0; n < NIBBLES; n++) begin
      nib_cnt = 3'(g[4*n]) + 3'(g[4*n+1]) + 3'(g[4*n+2]) + 3'(g[4*n+3]);
      total   = total + SCORE_W'(nib_cnt);
    end
    return total;
  endfunction

endpackage

>>> rtl/gafrs_mod_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gafrs_mod_unit - iterative remainder unit
// Restoring division, one dividend bit per cycle; returns the remainder only.
// ----------------------------------------------------------------------------
module gafrs_mod_unit
  import gafrs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [RAND_BITS-1:0] dividend,
  input  logic [SUM_W-1:0]     divisor,
  output logic                 done,
  output logic [SUM_W-1:0]     remainder
);

  localparam int CNT_W = $clog2(RAND_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RAND_BITS - 1);

  logic                 busy;
  logic [CNT_W-1:0]     count;
  logic [RAND_BITS-1:0] dvd;
  logic [SUM_W-1:0]     dsr;
  logic [SUM_W-1:0]     rem;
  logic [SUM_W:0]       trial;
  logic [SUM_W-1:0]     rem_next;

  // The partial remainder stays below the divisor, so one subtract per step.
  always_comb begin
    trial = {rem, dvd[RAND_BITS-1]};
    if (trial >= {1'b0, dsr}) begin
      rem_next = SUM_W'(trial - {1'b0, dsr});
    end else begin
      rem_next = trial[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && count == CNT_LAST) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      count <= '0;
      rem   <= '0;
      dvd   <= dividend;
      dsr   <= divisor;
    end else if (busy) begin
      count <= count + 1'b1;
      rem   <= rem_next;
      dvd   <= {dvd[RAND_BITS-2:0], 1'b0};
    end
  end

  assign remainder = rem;

endmodule

>>> rtl/ga_fitness_roulette_selector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ga_fitness_roulette_selector - fitness table with roulette-wheel selection
// Scores genes, keeps total, best, worst and ideal statistics, picks parents.
// ----------------------------------------------------------------------------
// The block takes one request at a time. An evaluate request scores a 16-bit
// gene as its count of one bits, a record request supplies the fitness
// directly; both store the fitness in a 64-entry table and update the running
// total (saturating at 2047), the best and worst entries (earlier entry wins
// a tie) and a sticky ideal flag holding the latest entry equal to
// target_score. A set first flag clears these statistics before the request
// acts. A select request reduces random_word modulo the total and walks the
// table from entry 0 for the first entry whose running sum exceeds that
// value; a zero total returns entry 0 with empty_error set. Store requests,
// unused op codes and zero-total selects go from the execute state straight
// to the finish state, which loads the result. Any other select first runs
// the remainder unit, which retires one random bit per cycle; then a prime
// state starts the table read and, as the table has one read port, the walk
// visits one entry per cycle. The next request can be accepted on the cycle
// after the result is loaded. s_tready is high only while the sequencer is
// idle; a finished result sits in the output register and the next request
// may be accepted while it waits. A result that finds the previous one still
// unaccepted holds the sequencer until that one is taken. Entries never
// written must not be reached by a select walk.
module ga_fitness_roulette_selector
  import gafrs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // Request stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // {random_word[43:28], given_score[27:23], genome[22:7], slot[6:1], first[0]}
  input  logic [47:0]  s_tdata,
  // {op[1:0]}
  input  logic [1:0]   s_tuser,
  // Result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // {empty_error[51], chosen_slot[50:45], score_sum[44:34], worst_score[33:29],
  //  worst_slot[28:23], best_score[22:18], best_slot[17:12], ideal_slot[11:6],
  //  ideal_seen[5], score[4:0]}
  output logic [55:0]  m_tdata,
  // Configuration: target_score
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [4:0]   cfg_data
);

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(POP_SIZE - 1);

  state_t state, state_next;

  // Target register
  logic [SCORE_W-1:0] target_score;

  // Latched request
  op_t                  item_op;
  logic                 item_first;
  logic [SLOT_W-1:0]    item_slot;
  logic [GENE_BITS-1:0] item_genome;
  logic [SCORE_W-1:0]   item_given;
  logic [RAND_BITS-1:0] item_rand;

  // Statistics
  logic [SUM_W-1:0]   sum;
  logic               best_v, worst_v, ideal_v;
  logic [SLOT_W-1:0]  best_slot, worst_slot, ideal_slot;
  logic [SCORE_W-1:0] best_score, worst_score;

  logic [SUM_W-1:0]   sum_next;
  logic               best_v_next, worst_v_next, ideal_v_next;
  logic [SLOT_W-1:0]  best_slot_next, worst_slot_next, ideal_slot_next;
  logic [SCORE_W-1:0] best_score_next, worst_score_next;

  // Per-request result
  logic [SCORE_W-1:0] item_score;
  logic               do_store;
  logic [SCORE_W-1:0] res_score;
  logic [SLOT_W-1:0]  res_chosen;
  logic               res_err;

  // Score table and walk
  logic [SCORE_W-1:0] score_mem [POP_SIZE];
  logic [SCORE_W-1:0] mem_q;
  logic [SLOT_W-1:0]  walk_addr;
  logic [SLOT_W-1:0]  walk_idx;
  logic [SUM_W:0]     cum;
  logic [SUM_W:0]     cum_next;
  logic               walk_hit;

  // Remainder unit
  logic               div_start;
  logic               div_done;
  logic [SUM_W-1:0]   div_rem;

  logic               out_free;
  logic               mem_we;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_score <= SCORE_W'(TARGET_RESET);
    end else if (cfg_valid && cfg_ready) begin
      target_score <= cfg_data;
    end
  end

  // Capture the request when it is accepted.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_op     <= op_t'(s_tuser);
      item_first  <= s_tdata[0];
      item_slot   <= s_tdata[6:1];
      item_genome <= s_tdata[22:7];
      item_given  <= s_tdata[27:23];
      item_rand   <= s_tdata[43:28];
    end
  end

  // Statistics update: optional clear, then the store of this request.
  always_comb begin
    item_score = (item_op == OP_EVAL) ? gene_score(item_genome) : item_given;
    do_store   = (item_op == OP_EVAL || item_op == OP_RECORD) &&
                 ({1'b0, item_slot} < (SLOT_W+1)'(POP_SIZE));

    sum_next         = item_first ? '0 : sum;
    best_v_next      = item_first ? 1'b0 : best_v;
    best_slot_next   = best_slot;
    best_score_next  = best_score;
    worst_v_next     = item_first ? 1'b0 : worst_v;
    worst_slot_next  = worst_slot;
    worst_score_next = worst_score;
    ideal_v_next     = item_first ? 1'b0 : ideal_v;
    ideal_slot_next  = ideal_slot;

    if (do_store) begin
      if (item_score == target_score) begin
        ideal_v_next    = 1'b1;
        ideal_slot_next = item_slot;
      end
      if (!best_v_next || item_score > best_score) begin
        best_v_next     = 1'b1;
        best_slot_next  = item_slot;
        best_score_next = item_score;
      end
      if (!worst_v_next || item_score < worst_score) begin
        worst_v_next     = 1'b1;
        worst_slot_next  = item_slot;
        worst_score_next = item_score;
      end
      if (({1'b0, sum_next} + (SUM_W+1)'(item_score)) > {1'b0, SUM_MAX}) begin
        sum_next = SUM_MAX;
      end else begin
        sum_next = sum_next + SUM_W'(item_score);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum     <= '0;
      best_v  <= 1'b0;
      worst_v <= 1'b0;
      ideal_v <= 1'b0;
    end else if (state == ST_EXEC) begin
      sum     <= sum_next;
      best_v  <= best_v_next;
      worst_v <= worst_v_next;
      ideal_v <= ideal_v_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      best_slot   <= best_slot_next;
      best_score  <= best_score_next;
      worst_slot  <= worst_slot_next;
      worst_score <= worst_score_next;
      ideal_slot  <= ideal_slot_next;
    end
  end

  // Score table: one write port, one registered read port for the walk.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      score_mem[item_slot] <= item_score;
    end
    mem_q <= score_mem[walk_addr];
  end

  gafrs_mod_unit u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (item_rand),
    .divisor   (sum_next),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign cum_next = cum + (SUM_W+1)'(mem_q);
  assign walk_hit = (cum_next > {1'b0, div_rem}) || (walk_idx == SLOT_LAST);

  // Walk bookkeeping and per-request result.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_EXEC: begin
        res_score  <= (item_op == OP_EVAL || item_op == OP_RECORD) ? item_score : '0;
        res_chosen <= '0;
        res_err    <= (item_op == OP_SELECT) && (sum_next == '0);
        walk_addr  <= '0;
      end
      ST_PRIME: begin
        walk_addr <= walk_addr + 1'b1;
        walk_idx  <= '0;
        cum       <= '0;
      end
      ST_WALK: begin
        walk_addr <= walk_addr + 1'b1;
        walk_idx  <= walk_idx + 1'b1;
        cum       <= cum_next;
        if (walk_hit) begin
          res_chosen <= walk_idx;
        end
      end
      default: begin
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (item_op == OP_SELECT && sum_next != '0) state_next = ST_MOD;
        else state_next = ST_FINISH;
      end
      ST_MOD: begin
        if (div_done) state_next = ST_PRIME;
      end
      ST_PRIME: begin
        state_next = ST_WALK;
      end
      ST_WALK: begin
        if (walk_hit) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_tready  = 1'b0;
    div_start = 1'b0;
    mem_we    = 1'b0;
    unique case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_EXEC: begin
        mem_we    = do_store;
        div_start = (item_op == OP_SELECT) && (sum_next != '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      m_tdata <= {4'b0000,
                  res_err,
                  res_chosen,
                  sum,
                  worst_v ? worst_score : '0,
                  worst_v ? worst_slot : '0,
                  best_v ? best_score : '0,
                  best_v ? best_slot : '0,
                  ideal_v ? ideal_slot : '0,
                  ideal_v,
                  res_score};
    end
  end

`ifndef SYNTHESIS
  // The walk only runs against a nonzero total, with the remainder below it.
  a_walk_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (sum != '0 && div_rem < sum))
    else $error("walk running with a remainder not below the total");

  // The remainder unit finishes only while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_MOD))
    else $error("remainder unit finished outside the modulo step");

  // A zero-total select reports entry 0.
  a_err_slot: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[51]) |-> (m_tdata[50:45] == '0 && m_tdata[44:34] == '0))
    else $error("empty error reported with a chosen entry or a nonzero total");

  // No request is taken while a previous one is still being worked on.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_EXEC))
    else $error("accepted request did not enter execution");
`endif

endmodule
